// ===== rtl/core/tpit_pkg.sv =====
// shared types, constants and the axis schedule for the triangle pair intersection test
package tpit_pkg;

    localparam int EPS_BITS = 40;
    localparam int AX_BITS = 4;
    localparam int STEP_BITS = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [AX_BITS-1:0] AX_LAST = 4'd10;

    localparam logic [STEP_BITS-1:0] CROSS_LAST = 4'd2;
    localparam logic [STEP_BITS-1:0] DOT_LAST = 4'd11;
    localparam logic [STEP_BITS-1:0] DRAIN_LAST = 4'd1;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EDGE,
        ST_CROSS,
        ST_GAP,
        ST_DOT,
        ST_DRAIN,
        ST_EVAL,
        ST_DONE
    } st_t;

    // what the shared multiply unit is computing in a given pass
    typedef enum logic [1:0]
    {
        MK_CROSS,
        MK_LO,
        MK_HI
    } mk_t;

    typedef struct packed
    {
        logic vld;
        mk_t  kind;
        logic q_set;
        logic first;
    } tag1_t;

    typedef struct packed
    {
        logic vld;
        logic q_set;
        logic first;
    } tag2_t;

    // edge indexes 0..2 are reference edges, 3..5 are test edges
    typedef struct packed
    {
        logic [2:0] e1_sel;
        logic [2:0] e2_sel;
        logic       p_is_s;
    } plan_t;

    // axis 0: reference face normal, axis 1: test face normal, then edge pairs
    function automatic plan_t axis_plan(input logic [AX_BITS-1:0] ax);
        plan_t p;
        p.e1_sel = 3'd0;
        p.e2_sel = 3'd3;
        p.p_is_s = 1'b0;
        unique case (ax)
            4'd0:
            begin
                p.e1_sel = 3'd0;
                p.e2_sel = 3'd2;
                p.p_is_s = 1'b1;
            end
            4'd1:
            begin
                p.e1_sel = 3'd3;
                p.e2_sel = 3'd5;
            end
            4'd2:  p.e2_sel = 3'd3;
            4'd3:  p.e2_sel = 3'd4;
            4'd4:  p.e2_sel = 3'd5;
            4'd5:
            begin
                p.e1_sel = 3'd1;
                p.e2_sel = 3'd3;
            end
            4'd6:
            begin
                p.e1_sel = 3'd1;
                p.e2_sel = 3'd4;
            end
            4'd7:
            begin
                p.e1_sel = 3'd1;
                p.e2_sel = 3'd5;
            end
            4'd8:
            begin
                p.e1_sel = 3'd2;
                p.e2_sel = 3'd3;
            end
            4'd9:
            begin
                p.e1_sel = 3'd2;
                p.e2_sel = 3'd4;
            end
            4'd10:
            begin
                p.e1_sel = 3'd2;
                p.e2_sel = 3'd5;
            end
            default:
            begin
                p.e1_sel = 3'd0;
                p.e2_sel = 3'd3;
            end
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/tpit_dot3.sv =====
// shared three-lane signed multiply and sum unit with registered result
module tpit_dot3 #(
    parameter int XW = 20,
    parameter int YW = 19
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [XW-1:0]     x [3],
    input  logic signed [YW-1:0]     y [3],
    output logic signed [XW+YW+1:0] sum
);

    localparam int MW = XW + YW + 2;

    logic signed [MW-1:0] prod [3];
    logic signed [MW-1:0] sum_reg;
    logic signed [MW-1:0] sum_next;

    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            prod[m] = MW'(x[m]) * MW'(y[m]);
        end
        sum_next = prod[0] + prod[1] + prod[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== rtl/core/triangle_pair_intersect_test_top.sv =====
// triangle pair intersection test by separating axes, top level
//
// A load transaction (operation 0) stores its triangle as the reference when
// it is taken. A test transaction (operation 1) checks its triangle against the
// reference on eleven axes (both face normals, then the nine reference edge x
// test edge cross products) and returns one hit flag. Each axis runs through
// edge setup, three cross product passes, a bubble, twelve projection passes
// (six corners, low and high half of the axis each), pipeline drain and the
// verdict, all through one shared three-lane multiply unit. The test stops at
// the first separating axis, so it tries between 1 and 11 axes, and the block
// takes no new transaction until it has handed on the result. The tolerance
// register is written through the cfg channel; the user must write it only
// while the block is idle, which the block itself does not enforce. The cfg
// channel is always ready.
module triangle_pair_intersect_test_top #(
    parameter int COORD_BITS = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                operation,
    input  logic signed [COORD_BITS-1:0]        a_x,
    input  logic signed [COORD_BITS-1:0]        a_y,
    input  logic signed [COORD_BITS-1:0]        a_z,
    input  logic signed [COORD_BITS-1:0]        b_x,
    input  logic signed [COORD_BITS-1:0]        b_y,
    input  logic signed [COORD_BITS-1:0]        b_z,
    input  logic signed [COORD_BITS-1:0]        c_x,
    input  logic signed [COORD_BITS-1:0]        c_y,
    input  logic signed [COORD_BITS-1:0]        c_z,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                hit,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpit_pkg::EPS_BITS-1:0]       eps_threshold
);

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int XW = DW + 1;
    localparam int YW = DW;
    localparam int MW = XW + YW + 2;
    localparam int AW = 2 * DW + 1;
    localparam int LW = DW;
    localparam int PW = MW + LW;
    localparam int DFW = PW + 1;
    localparam int CW = (DFW > tpit_pkg::EPS_BITS + 1) ? DFW : tpit_pkg::EPS_BITS + 1;

    tpit_pkg::st_t state_reg;
    tpit_pkg::st_t state_next;
    logic [tpit_pkg::AX_BITS-1:0] ax_reg;
    logic [tpit_pkg::AX_BITS-1:0] ax_next;
    logic [tpit_pkg::STEP_BITS-1:0] step_reg;
    logic [tpit_pkg::STEP_BITS-1:0] step_next;
    logic verdict_reg;
    logic verdict_next;

    logic [tpit_pkg::EPS_BITS-1:0] eps_reg;
    logic signed [CB-1:0] ref_reg [9];
    logic signed [CB-1:0] tri_reg [9];

    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [AW-1:0] axis_vec_reg [3];

    tpit_pkg::tag1_t tag1_reg;
    tpit_pkg::tag1_t tag1_next;
    tpit_pkg::tag2_t tag2_reg;
    tpit_pkg::tag2_t tag2_next;

    logic signed [MW-1:0] lo_reg;
    logic signed [PW-1:0] dot_reg;
    logic signed [PW-1:0] dot_full;
    logic signed [PW-1:0] pmax_reg;
    logic signed [PW-1:0] pmin_reg;
    logic signed [PW-1:0] qmax_reg;
    logic signed [PW-1:0] qmin_reg;

    logic result_valid_reg;
    logic hit_reg;

    logic item_accept;
    logic edge_load;
    logic issue_vld;
    tpit_pkg::mk_t issue_kind;
    logic result_load;

    logic signed [CB-1:0] in_coords [9];
    logic signed [CB-1:0] corners [6][3];
    logic signed [DW-1:0] edge_vec [6][3];
    tpit_pkg::plan_t plan;

    logic [2:0] pt;
    logic q_pt;
    logic [2:0] corner_idx;
    logic [2:0] corner_sel;
    logic tri_is_s;

    logic signed [XW-1:0] mac_x [3];
    logic signed [YW-1:0] mac_y [3];
    logic signed [MW-1:0] prod;

    logic signed [CW-1:0] gap_hi;
    logic signed [CW-1:0] gap_lo;
    logic signed [CW-1:0] eps_ext;
    logic straddle;

    assign in_coords[0] = a_x;
    assign in_coords[1] = a_y;
    assign in_coords[2] = a_z;
    assign in_coords[3] = b_x;
    assign in_coords[4] = b_y;
    assign in_coords[5] = b_z;
    assign in_coords[6] = c_x;
    assign in_coords[7] = c_y;
    assign in_coords[8] = c_z;

    assign item_accept = item_valid && !item_stall;
    assign cfg_ready = 1'b1;

    // corners 0..2 reference, 3..5 test; edges run A-B, B-C, C-A
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                corners[k][m] = ref_reg[3 * k + m];
                corners[k + 3][m] = tri_reg[3 * k + m];
            end
        end
        for (int e = 0; e < 6; e++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                edge_vec[e][m] = DW'(corners[e][m])
                    - DW'(corners[(e / 3) * 3 + ((e % 3) + 1) % 3][m]);
            end
        end
    end

    assign plan = tpit_pkg::axis_plan(ax_reg);

    // projection pass: corners 0..2 of the p set, then 0..2 of the q set
    assign pt = step_reg[3:1];
    assign q_pt = (pt >= 3'd3);
    assign corner_idx = q_pt ? pt - 3'd3 : pt;
    assign tri_is_s = plan.p_is_s ^ q_pt;
    assign corner_sel = tri_is_s ? corner_idx + 3'd3 : corner_idx;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ax_next = ax_reg;
        step_next = step_reg;
        verdict_next = verdict_reg;
        unique case (state_reg)
            tpit_pkg::ST_IDLE:
            begin
                if (item_accept && operation == tpit_pkg::OP_TEST)
                begin
                    state_next = tpit_pkg::ST_EDGE;
                    ax_next = '0;
                end
            end
            tpit_pkg::ST_EDGE:
            begin
                state_next = tpit_pkg::ST_CROSS;
                step_next = '0;
            end
            tpit_pkg::ST_CROSS:
            begin
                if (step_reg == tpit_pkg::CROSS_LAST)
                begin
                    state_next = tpit_pkg::ST_GAP;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            tpit_pkg::ST_GAP:
            begin
                state_next = tpit_pkg::ST_DOT;
                step_next = '0;
            end
            tpit_pkg::ST_DOT:
            begin
                if (step_reg == tpit_pkg::DOT_LAST)
                begin
                    state_next = tpit_pkg::ST_DRAIN;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            tpit_pkg::ST_DRAIN:
            begin
                if (step_reg == tpit_pkg::DRAIN_LAST)
                begin
                    state_next = tpit_pkg::ST_EVAL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            tpit_pkg::ST_EVAL:
            begin
                verdict_next = straddle;
                if (!straddle || ax_reg == tpit_pkg::AX_LAST)
                begin
                    state_next = tpit_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tpit_pkg::ST_EDGE;
                    ax_next = ax_reg + 1'b1;
                end
            end
            tpit_pkg::ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = tpit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpit_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        edge_load = 1'b0;
        issue_vld = 1'b0;
        issue_kind = tpit_pkg::MK_CROSS;
        result_load = 1'b0;
        unique case (state_reg)
            tpit_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            tpit_pkg::ST_EDGE:
            begin
                edge_load = 1'b1;
            end
            tpit_pkg::ST_CROSS:
            begin
                issue_vld = 1'b1;
                issue_kind = tpit_pkg::MK_CROSS;
            end
            tpit_pkg::ST_DOT:
            begin
                issue_vld = 1'b1;
                issue_kind = step_reg[0] ? tpit_pkg::MK_HI : tpit_pkg::MK_LO;
            end
            tpit_pkg::ST_DONE:
            begin
                result_load = !result_valid_reg || !result_stall;
            end
            tpit_pkg::ST_GAP, tpit_pkg::ST_DRAIN, tpit_pkg::ST_EVAL:
            begin
                issue_vld = 1'b0;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // operand select for the shared unit
    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            mac_x[m] = '0;
            mac_y[m] = '0;
        end
        unique case (issue_kind)
            tpit_pkg::MK_CROSS:
            begin
                // e registers are rotated so slot 0 holds the current component
                mac_x[0] = XW'(e1_reg[1]);
                mac_y[0] = e2_reg[2];
                mac_x[1] = -XW'(e1_reg[2]);
                mac_y[1] = e2_reg[1];
            end
            tpit_pkg::MK_LO:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    mac_x[m] = $signed({1'b0, axis_vec_reg[m][LW-1:0]});
                    mac_y[m] = YW'(corners[corner_sel][m]);
                end
            end
            tpit_pkg::MK_HI:
            begin
                for (int m = 0; m < 3; m++)
                begin
                    mac_x[m] = $signed(axis_vec_reg[m][AW-1:LW]);
                    mac_y[m] = YW'(corners[corner_sel][m]);
                end
            end
            default:
            begin
                mac_x[0] = '0;
            end
        endcase
    end

    tpit_dot3 #(
        .XW(XW),
        .YW(YW)
    ) u_dot3 (
        .clk(clk),
        .en(issue_vld),
        .x(mac_x),
        .y(mac_y),
        .sum(prod)
    );

    always_comb
    begin
        tag1_next.vld = issue_vld;
        tag1_next.kind = issue_kind;
        tag1_next.q_set = q_pt;
        tag1_next.first = (corner_idx == 3'd0);
        tag2_next.vld = tag1_reg.vld && tag1_reg.kind == tpit_pkg::MK_HI;
        tag2_next.q_set = tag1_reg.q_set;
        tag2_next.first = tag1_reg.first;
    end

    assign dot_full = PW'(lo_reg) + (PW'(prod) <<< LW);

    // an axis separates unless pmax - qmin and qmax - pmin both exceed eps
    always_comb
    begin
        eps_ext = $signed(CW'(eps_reg));
        gap_hi = CW'(pmax_reg) - CW'(qmin_reg);
        gap_lo = CW'(qmax_reg) - CW'(pmin_reg);
        straddle = (gap_hi > eps_ext) && (gap_lo > eps_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpit_pkg::ST_IDLE;
            ax_reg <= '0;
            step_reg <= '0;
            verdict_reg <= 1'b0;
            eps_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                ref_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ax_reg <= ax_next;
            step_reg <= step_next;
            verdict_reg <= verdict_next;
            tag1_reg <= tag1_next;
            tag2_reg <= tag2_next;
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= eps_threshold;
            end
            if (item_accept && operation == tpit_pkg::OP_LOAD)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    ref_reg[k] <= in_coords[k];
                end
            end
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && operation == tpit_pkg::OP_TEST)
        begin
            for (int k = 0; k < 9; k++)
            begin
                tri_reg[k] <= in_coords[k];
            end
        end

        if (edge_load)
        begin
            for (int m = 0; m < 3; m++)
            begin
                e1_reg[m] <= edge_vec[plan.e1_sel][m];
                e2_reg[m] <= edge_vec[plan.e2_sel][m];
            end
        end
        else if (issue_vld && issue_kind == tpit_pkg::MK_CROSS)
        begin
            for (int m = 0; m < 3; m++)
            begin
                e1_reg[m] <= e1_reg[(m + 1) % 3];
                e2_reg[m] <= e2_reg[(m + 1) % 3];
            end
        end

        if (tag1_reg.vld)
        begin
            unique case (tag1_reg.kind)
                tpit_pkg::MK_CROSS:
                begin
                    // components arrive x, y, z and shift in from the top
                    axis_vec_reg[0] <= axis_vec_reg[1];
                    axis_vec_reg[1] <= axis_vec_reg[2];
                    axis_vec_reg[2] <= $signed(prod[AW-1:0]);
                end
                tpit_pkg::MK_LO:
                begin
                    lo_reg <= prod;
                end
                tpit_pkg::MK_HI:
                begin
                    dot_reg <= dot_full;
                end
                default:
                begin
                    lo_reg <= lo_reg;
                end
            endcase
        end

        if (tag2_reg.vld)
        begin
            if (tag2_reg.q_set)
            begin
                if (tag2_reg.first || dot_reg > qmax_reg)
                begin
                    qmax_reg <= dot_reg;
                end
                if (tag2_reg.first || dot_reg < qmin_reg)
                begin
                    qmin_reg <= dot_reg;
                end
            end
            else
            begin
                if (tag2_reg.first || dot_reg > pmax_reg)
                begin
                    pmax_reg <= dot_reg;
                end
                if (tag2_reg.first || dot_reg < pmin_reg)
                begin
                    pmin_reg <= dot_reg;
                end
            end
        end

        if (result_load)
        begin
            hit_reg <= verdict_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign hit = hit_reg;

`ifndef SYNTH
    // a result only appears after the sequencer has finished a test
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == tpit_pkg::ST_DONE))
        else $error("result raised without a finished test");

    // the high half of a projection always follows its low half
    assert property (@(posedge clk) disable iff (!rst_n)
        (tag1_reg.vld && tag1_reg.kind == tpit_pkg::MK_HI)
        |-> $past(tag1_reg.vld && tag1_reg.kind == tpit_pkg::MK_LO))
        else $error("high projection pass without low pass");

    // the verdict reads min and max only after the pipeline has drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpit_pkg::ST_EVAL) |-> (!tag1_reg.vld && !tag2_reg.vld))
        else $error("axis evaluated with projections still in flight");

    // the axis counter stays within the eleven axes while a test runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tpit_pkg::ST_IDLE && state_reg != tpit_pkg::ST_DONE)
        |-> (ax_reg <= tpit_pkg::AX_LAST))
        else $error("axis counter out of range");
`endif

endmodule
